@@ rtl/stkt_pkg.sv @@
package stkt_pkg;

    localparam int ACCOUNT_ENTRIES        = 256;
    localparam int CURRENCIES_PER_ACCOUNT = 4;
    localparam int CODE_BITS              = 24;

    localparam int ID_W    = 31;
    localparam int VAL_W   = 32;
    localparam int POS_W   = $clog2(ACCOUNT_ENTRIES);
    localparam int CNT_W   = $clog2(ACCOUNT_ENTRIES + 1);
    localparam int ECNT_W  = $clog2(CURRENCIES_PER_ACCOUNT + 1);
    localparam int IX_W    = $clog2(ACCOUNT_ENTRIES * CURRENCIES_PER_ACCOUNT);
    localparam int REC_DEPTH = ACCOUNT_ENTRIES * CURRENCIES_PER_ACCOUNT;

    // operation codes
    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_GET    = 2'd1;
    localparam logic [1:0] FUNC_UPDATE = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_PRESENT  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0]              func;
        logic [ID_W-1:0]         account_id;
        logic [CODE_BITS-1:0]    ccy_code;
        logic signed [VAL_W-1:0] cash_in;
        logic signed [VAL_W-1:0] buy_balance_in;
        logic signed [VAL_W-1:0] buy_fee_in;
        logic signed [VAL_W-1:0] sale_balance_in;
        logic signed [VAL_W-1:0] sale_fee_in;
    } in_word_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] cash_out;
        logic signed [VAL_W-1:0] buy_balance_out;
        logic signed [VAL_W-1:0] buy_fee_out;
        logic signed [VAL_W-1:0] sale_balance_out;
        logic signed [VAL_W-1:0] sale_fee_out;
        logic                    modified;
    } out_word_t;

    // one stored record: code, five balances, modified flag
    typedef struct packed {
        logic [CODE_BITS-1:0]    code;
        logic [VAL_W-1:0]        cash;
        logic [VAL_W-1:0]        buy_balance;
        logic [VAL_W-1:0]        buy_fee;
        logic [VAL_W-1:0]        sale_balance;
        logic [VAL_W-1:0]        sale_fee;
        logic                    modified;
    } rec_t;

    // sorted key entry: account id and its slot number
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] slot;
    } key_t;

endpackage

@@ rtl/stkt_in_if.sv @@
interface stkt_in_if;
    import stkt_pkg::*;
    logic     valid;
    logic     ready;
    in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/stkt_out_if.sv @@
interface stkt_out_if;
    import stkt_pkg::*;
    logic      valid;
    logic      ready;
    out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/sorted_two_level_key_table.sv @@
// Channel  Dir  Word        Meaning
// req      in   in_word_t   operation, account id, currency code, balances
// rsp      out  out_word_t  status, stored balances, modified flag
//
// Search: a binary search over the sorted account keys, up to nine probes
// at 256 accounts, then a final check of the found key; the currency scan
// reads the account's records one entry at a time.
// Adding a new account shifts the sorted key memory up one entry at a time
// (one read, one write on the key RAM) to open the insert position.
// Reset clears the account count and control; memories hold no reset value.
// The block takes one word at a time; a finished result waits in the output
// register while the next word is accepted.
module sorted_two_level_key_table
    import stkt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    stkt_in_if.sink    req,
    stkt_out_if.source rsp
);
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PROBE    = 4'd1;
    localparam logic [3:0] S_PROBE_W  = 4'd2;
    localparam logic [3:0] S_CHECK_W  = 4'd3;
    localparam logic [3:0] S_SHIFT_RD = 4'd4;
    localparam logic [3:0] S_SHIFT_WR = 4'd5;
    localparam logic [3:0] S_INSERT   = 4'd6;
    localparam logic [3:0] S_CNT_W    = 4'd7;
    localparam logic [3:0] S_SCAN     = 4'd8;
    localparam logic [3:0] S_SCAN_W   = 4'd9;
    localparam logic [3:0] S_FIN      = 4'd10;

    logic [3:0]        st_reg, st_next;
    in_word_t          q_reg, q_next;
    logic [CNT_W-1:0]  lo_reg, lo_next, hi_reg, hi_next, k_reg, k_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [POS_W-1:0]  slot_reg, slot_next;
    logic [ECNT_W-1:0] n_reg, n_next, e_reg, e_next;
    out_word_t         res_reg, res_next;
    out_word_t         rsp_data_reg, rsp_data_next;
    logic              ovalid_reg, ovalid_next;

    logic              key_we;
    logic [POS_W-1:0]  key_waddr, key_raddr;
    key_t              key_wdata, key_rdata;
    logic              cnt_we;
    logic [POS_W-1:0]  cnt_waddr, cnt_raddr;
    logic [ECNT_W-1:0] cnt_wdata, cnt_rdata;
    logic              rec_we;
    logic [IX_W-1:0]   rec_waddr, rec_raddr;
    rec_t              rec_wdata, rec_rdata;

    logic [CNT_W:0]    mid_sum;
    logic [CNT_W-1:0]  mid;
    logic              miss;
    logic [IX_W-1:0]   slot_base;
    out_word_t         res_in, res_stored, res_zero;
    rec_t              rec_in;

    stkt_ram #(.WIDTH($bits(key_t)), .DEPTH(ACCOUNT_ENTRIES)) u_key_ram (
        .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
        .raddr(key_raddr), .rdata(key_rdata)
    );
    stkt_ram #(.WIDTH(ECNT_W), .DEPTH(ACCOUNT_ENTRIES)) u_cnt_ram (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(cnt_raddr), .rdata(cnt_rdata)
    );
    stkt_ram #(.WIDTH($bits(rec_t)), .DEPTH(REC_DEPTH)) u_rec_ram (
        .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
        .raddr(rec_raddr), .rdata(rec_rdata)
    );

    assign req.ready = (st_reg == S_IDLE);
    assign rsp.valid = ovalid_reg;
    assign rsp.data  = rsp_data_reg;

    // form result and record words
    always_comb
    begin
        mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid       = mid_sum[CNT_W:1];
        slot_base = IX_W'(slot_reg) * IX_W'(CURRENCIES_PER_ACCOUNT);

        res_zero  = '0;
        res_in.status           = ST_OK;
        res_in.cash_out         = q_reg.cash_in;
        res_in.buy_balance_out  = q_reg.buy_balance_in;
        res_in.buy_fee_out      = q_reg.buy_fee_in;
        res_in.sale_balance_out = q_reg.sale_balance_in;
        res_in.sale_fee_out     = q_reg.sale_fee_in;
        res_in.modified         = 1'b0;

        res_stored.status           = ST_OK;
        res_stored.cash_out         = rec_rdata.cash;
        res_stored.buy_balance_out  = rec_rdata.buy_balance;
        res_stored.buy_fee_out      = rec_rdata.buy_fee;
        res_stored.sale_balance_out = rec_rdata.sale_balance;
        res_stored.sale_fee_out     = rec_rdata.sale_fee;
        res_stored.modified         = rec_rdata.modified;

        rec_in.code         = q_reg.ccy_code;
        rec_in.cash         = q_reg.cash_in;
        rec_in.buy_balance  = q_reg.buy_balance_in;
        rec_in.buy_fee      = q_reg.buy_fee_in;
        rec_in.sale_balance = q_reg.sale_balance_in;
        rec_in.sale_fee     = q_reg.sale_fee_in;
        rec_in.modified     = 1'b0;
    end

    // sequencer
    always_comb
    begin
        st_next       = st_reg;
        q_next        = q_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        k_next        = k_reg;
        count_next    = count_reg;
        slot_next     = slot_reg;
        n_next        = n_reg;
        e_next        = e_reg;
        res_next      = res_reg;
        rsp_data_next = rsp_data_reg;
        ovalid_next   = ovalid_reg;
        miss          = 1'b0;

        key_we    = 1'b0;
        key_waddr = lo_reg[POS_W-1:0];
        key_wdata = key_rdata;
        key_raddr = mid[POS_W-1:0];
        cnt_we    = 1'b0;
        cnt_waddr = slot_reg;
        cnt_wdata = '0;
        cnt_raddr = key_rdata.slot;
        rec_we    = 1'b0;
        rec_waddr = slot_base;
        rec_wdata = rec_in;
        rec_raddr = slot_base + IX_W'(e_reg);

        // drop the result once taken
        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (st_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    q_next  = req.data;
                    lo_next = '0;
                    hi_next = count_reg;
                    if (req.data.func != FUNC_ADD && req.data.func != FUNC_GET &&
                        req.data.func != FUNC_UPDATE)
                    begin
                        res_next        = res_zero;
                        res_next.status = ST_NOTFOUND;
                        st_next         = S_FIN;
                    end
                    else
                    begin
                        st_next = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    key_raddr = mid[POS_W-1:0];
                    st_next   = S_PROBE_W;
                end
                else if (lo_reg < count_reg)
                begin
                    key_raddr = lo_reg[POS_W-1:0];
                    st_next   = S_CHECK_W;
                end
                else
                begin
                    miss = 1'b1;
                end
            end
            S_PROBE_W:
            begin
                if (key_rdata.id < q_reg.account_id)
                begin
                    lo_next = mid + 1'b1;
                end
                else
                begin
                    hi_next = mid;
                end
                st_next = S_PROBE;
            end
            S_CHECK_W:
            begin
                if (key_rdata.id == q_reg.account_id)
                begin
                    slot_next = key_rdata.slot;
                    cnt_raddr = key_rdata.slot;
                    st_next   = S_CNT_W;
                end
                else
                begin
                    miss = 1'b1;
                end
            end
            S_SHIFT_RD:
            begin
                if (k_reg > lo_reg)
                begin
                    key_raddr = POS_W'(k_reg - 1'b1);
                    st_next   = S_SHIFT_WR;
                end
                else
                begin
                    st_next = S_INSERT;
                end
            end
            S_SHIFT_WR:
            begin
                key_we    = 1'b1;
                key_waddr = k_reg[POS_W-1:0];
                key_wdata = key_rdata;
                k_next    = k_reg - 1'b1;
                st_next   = S_SHIFT_RD;
            end
            S_INSERT:
            begin
                key_we         = 1'b1;
                key_waddr      = lo_reg[POS_W-1:0];
                key_wdata.id   = q_reg.account_id;
                key_wdata.slot = count_reg[POS_W-1:0];
                cnt_we         = 1'b1;
                cnt_waddr      = count_reg[POS_W-1:0];
                cnt_wdata      = ECNT_W'(1);
                rec_we         = 1'b1;
                rec_waddr      = IX_W'(count_reg[POS_W-1:0]) *
                                 IX_W'(CURRENCIES_PER_ACCOUNT);
                count_next     = count_reg + 1'b1;
                res_next       = res_in;
                st_next        = S_FIN;
            end
            S_CNT_W:
            begin
                n_next  = cnt_rdata;
                e_next  = '0;
                st_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (e_reg < n_reg && e_reg < ECNT_W'(CURRENCIES_PER_ACCOUNT))
                begin
                    rec_raddr = slot_base + IX_W'(e_reg);
                    st_next   = S_SCAN_W;
                end
                else if (q_reg.func == FUNC_ADD)
                begin
                    if (n_reg >= ECNT_W'(CURRENCIES_PER_ACCOUNT))
                    begin
                        res_next        = res_zero;
                        res_next.status = ST_FULL;
                    end
                    else
                    begin
                        rec_we    = 1'b1;
                        rec_waddr = slot_base + IX_W'(n_reg);
                        cnt_we    = 1'b1;
                        cnt_waddr = slot_reg;
                        cnt_wdata = n_reg + 1'b1;
                        res_next  = res_in;
                    end
                    st_next = S_FIN;
                end
                else
                begin
                    res_next        = res_zero;
                    res_next.status = ST_NOTFOUND;
                    st_next         = S_FIN;
                end
            end
            S_SCAN_W:
            begin
                if (rec_rdata.code == q_reg.ccy_code)
                begin
                    res_next = res_stored;
                    if (q_reg.func == FUNC_ADD)
                    begin
                        res_next.status = ST_PRESENT;
                    end
                    else if (q_reg.func == FUNC_UPDATE)
                    begin
                        rec_we             = 1'b1;
                        rec_waddr          = slot_base + IX_W'(e_reg);
                        rec_wdata.modified = 1'b1;
                        res_next           = res_in;
                        res_next.modified  = 1'b1;
                    end
                    st_next = S_FIN;
                end
                else
                begin
                    e_next  = e_reg + 1'b1;
                    st_next = S_SCAN;
                end
            end
            S_FIN:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    rsp_data_next = res_reg;
                    ovalid_next   = 1'b1;
                    st_next       = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase

        // handle an account that is not in the table
        if (miss)
        begin
            if (q_reg.func != FUNC_ADD)
            begin
                res_next        = res_zero;
                res_next.status = ST_NOTFOUND;
                st_next         = S_FIN;
            end
            else if (count_reg >= CNT_W'(ACCOUNT_ENTRIES))
            begin
                res_next        = res_zero;
                res_next.status = ST_FULL;
                st_next         = S_FIN;
            end
            else
            begin
                k_next  = count_reg;
                st_next = S_SHIFT_RD;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        k_reg        <= k_next;
        slot_reg     <= slot_next;
        n_reg        <= n_next;
        e_reg        <= e_next;
        res_reg      <= res_next;
        rsp_data_reg <= rsp_data_next;
    end
endmodule

@@ rtl/stkt_ram.sv @@
module stkt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/stkt_chk.sv @@
module stkt_chk
    import stkt_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input out_word_t  rsp_data
);
    // hold a stalled result word
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result word changed while stalled");

    // stay busy the cycle after taking a word
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready right after accept");

    // zero the cash, sale fee and modified fields on a not-found status
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status == ST_NOTFOUND |->
        rsp_data.cash_out == 0 && rsp_data.sale_fee_out == 0 && !rsp_data.modified)
        else $error("nonzero fields on not found");

    // zero the buy balance, buy fee and modified fields when full
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status == ST_FULL |->
        rsp_data.buy_balance_out == 0 && rsp_data.buy_fee_out == 0 && !rsp_data.modified)
        else $error("nonzero fields on full");
endmodule

bind sorted_two_level_key_table stkt_chk u_stkt_chk (
    .clk(clk),
    .rst_n(rst_n),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready),
    .rsp_data(rsp.data)
);
